// ===== hdl/kbi_pkg.sv =====
// ----------------------------------------------------------------------------
// kbi_pkg: shared types and constants for the keyframe brightness interpolator
// Field widths, the operation code and the controller/datapath interface.
// ----------------------------------------------------------------------------
package kbi_pkg;

  localparam int unsigned StampW   = 24;               // time stamp / offset width
  localparam int unsigned LevelW   = 8;                // brightness level width
  localparam int unsigned CountW   = 5;                // keyframe_count register width
  localparam int unsigned IdxW     = 4;                // key_index width
  localparam int unsigned SegW     = 4;                // segment_index width
  localparam int unsigned ProdW    = StampW + LevelW;  // elapsed time times level step
  localparam int unsigned DivSteps = LevelW;           // quotient bits of the divider
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Operation carried by an input word
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } kbi_op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;      // write one keyframe entry
    logic start;        // latch offset, point scan at entry 0
    logic advance;      // keep current entry as previous, step scan
    logic take_first;   // result is current entry (offset before first stamp)
    logic take_last;    // result is current entry (at or past last keyframe)
    logic capture;      // latch segment length, elapsed time and level step
    logic mult;         // form product, seed divider remainder
    logic div_step;     // one restoring division step
    logic take_interp;  // result is base level plus signed quotient
    logic out_load;     // move result into the output register
  } kbi_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic stamp_le;     // current stamp at or before the offset
    logic at_first;     // scan points at entry 0
    logic at_last;      // scan points at the last entry in use
  } kbi_stat_t;

endpackage

// ===== hdl/keyframe_brightness_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_brightness_interpolator: piecewise linear brightness from keyframes
// Loads keyframe entries and answers brightness queries at a play offset.
// ----------------------------------------------------------------------------
//  channel | handshake               | word
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | operation, key_index, stamp, level, offset
//  out     | out_valid_o/out_stall_i | brightness, segment_index
//  cfg     | cfg_we_i                | cfg_wdata_i -> keyframe_count
//
//  A load is written to the table as it is accepted. A query compares k entries
//  (1 to 16) one at a time over the one read port of the keyframe memory, and
//  then resolves to the first or last level, or interpolates with a multiply
//  and eight divider steps.
//  Reset clears control and sets keyframe_count to 1; the table is not cleared.
//  A finished word waits in the output register; loads are still taken then.
// ----------------------------------------------------------------------------
module keyframe_brightness_interpolator #(
  parameter int unsigned MAX_KEYFRAMES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kbi_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        in_operation_i,
  input  logic [kbi_pkg::IdxW-1:0]    in_key_index_i,
  input  logic [kbi_pkg::StampW-1:0]  in_key_stamp_ms_i,
  input  logic [kbi_pkg::LevelW-1:0]  in_key_level_i,
  input  logic [kbi_pkg::StampW-1:0]  in_play_offset_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kbi_pkg::LevelW-1:0]  out_brightness_o,
  output logic [kbi_pkg::SegW-1:0]    out_segment_index_o
);

  kbi_pkg::kbi_cmd_t  cmd;
  kbi_pkg::kbi_stat_t stat;

  // sequencer
  kbi_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_operation_i (in_operation_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // table and arithmetic
  kbi_datapath #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_key_index_i      (in_key_index_i),
    .in_key_stamp_ms_i   (in_key_stamp_ms_i),
    .in_key_level_i      (in_key_level_i),
    .in_play_offset_ms_i (in_play_offset_ms_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .out_brightness_o    (out_brightness_o),
    .out_segment_index_o (out_segment_index_o)
  );

endmodule

// ===== hdl/kbi_datapath.sv =====
// ----------------------------------------------------------------------------
// kbi_datapath: keyframe table, scan registers and interpolation arithmetic
// Holds the keyframe memory and count register, one 24x8 multiplier and a
// restoring divider that retires one quotient bit per step.
// ----------------------------------------------------------------------------
module kbi_datapath #(
  parameter int unsigned MAX_KEYFRAMES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kbi_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic [kbi_pkg::IdxW-1:0]    in_key_index_i,
  input  logic [kbi_pkg::StampW-1:0]  in_key_stamp_ms_i,
  input  logic [kbi_pkg::LevelW-1:0]  in_key_level_i,
  input  logic [kbi_pkg::StampW-1:0]  in_play_offset_ms_i,
  input  kbi_pkg::kbi_cmd_t           cmd_i,
  output kbi_pkg::kbi_stat_t          stat_o,
  output logic [kbi_pkg::LevelW-1:0]  out_brightness_o,
  output logic [kbi_pkg::SegW-1:0]    out_segment_index_o
);

  localparam int unsigned AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int unsigned NW = $clog2(MAX_KEYFRAMES + 1);
  localparam int unsigned EW = (NW > kbi_pkg::CountW) ? NW : kbi_pkg::CountW;
  localparam int unsigned SW = kbi_pkg::StampW;
  localparam int unsigned LW = kbi_pkg::LevelW;
  localparam int unsigned PW = kbi_pkg::ProdW;
  localparam int unsigned WW = SW + LW;  // one table word: stamp and level

  // keyframe table
  logic [WW-1:0] mem [MAX_KEYFRAMES];
  logic [WW-1:0] rd_q;

  logic [kbi_pkg::CountW-1:0] count_q;
  logic [EW-1:0]              count_ext;
  logic [NW-1:0]              n_c;

  logic [AW-1:0]  addr_q;
  logic [SW-1:0]  offset_q;
  logic [SW-1:0]  prev_stamp_q;
  logic [LW-1:0]  prev_level_q;
  logic [SW-1:0]  dt_q;
  logic [SW-1:0]  xt_q;
  logic [LW-1:0]  dmag_q;
  logic           neg_q;
  logic [LW-1:0]  base_q;
  logic [SW-1:0]  rem_q;
  logic [LW-1:0]  low_q;
  logic [LW-1:0]  quo_q;
  logic [LW-1:0]  res_level_q;
  logic [kbi_pkg::SegW-1:0] res_seg_q;
  logic [LW-1:0]  out_level_q;
  logic [kbi_pkg::SegW-1:0] out_seg_q;

  logic [SW-1:0]  rd_stamp;
  logic [LW-1:0]  rd_level;
  logic [PW-1:0]  prod;
  logic [SW+1:0]  trial;
  logic           trial_ok;
  logic           idx_ok;

  assign rd_stamp = rd_q[WW-1:LW];
  assign rd_level = rd_q[LW-1:0];

  // count in use: zero counts as one, large values saturate
  assign count_ext = EW'(count_q);
  always_comb begin
    if (count_q == '0) begin
      n_c = NW'(1);
    end else if (count_ext > EW'(MAX_KEYFRAMES)) begin
      n_c = NW'(MAX_KEYFRAMES);
    end else begin
      n_c = NW'(count_ext);
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= kbi_pkg::CountW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // table write and registered read
  assign idx_ok = (32'(in_key_index_i) < 32'(MAX_KEYFRAMES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && idx_ok) begin
      mem[AW'(in_key_index_i)] <= {in_key_stamp_ms_i, in_key_level_i};
    end
    rd_q <= mem[addr_q];
  end

  // scan pointer and previous entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q   <= '0;
      offset_q <= in_play_offset_ms_i;
    end else if (cmd_i.advance) begin
      addr_q       <= addr_q + AW'(1);
      prev_stamp_q <= rd_stamp;
      prev_level_q <= rd_level;
    end
  end

  // multiply and divide
  assign prod     = PW'(xt_q) * PW'(dmag_q);
  assign trial    = {1'b0, rem_q, low_q[LW-1]} - {2'b00, dt_q};
  assign trial_ok = ~trial[SW+1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dt_q   <= rd_stamp - prev_stamp_q;
      xt_q   <= offset_q - prev_stamp_q;
      neg_q  <= (rd_level < prev_level_q);
      dmag_q <= (rd_level < prev_level_q) ? (prev_level_q - rd_level)
                                          : (rd_level - prev_level_q);
      base_q <= prev_level_q;
    end
    // product over segment length is below 256, so its high part is below dt
    if (cmd_i.mult) begin
      rem_q <= prod[PW-1:LW];
      low_q <= prod[LW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ok ? trial[SW-1:0] : {rem_q[SW-2:0], low_q[LW-1]};
      low_q <= {low_q[LW-2:0], 1'b0};
      quo_q <= {quo_q[LW-2:0], trial_ok};
    end
  end

  // result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_first || cmd_i.take_last) begin
      res_level_q <= rd_level;
      res_seg_q   <= kbi_pkg::SegW'(addr_q);
    end else if (cmd_i.capture) begin
      res_seg_q   <= kbi_pkg::SegW'(addr_q - AW'(1));
    end else if (cmd_i.take_interp) begin
      res_level_q <= neg_q ? (base_q - quo_q) : (base_q + quo_q);
    end
    if (cmd_i.out_load) begin
      out_level_q <= res_level_q;
      out_seg_q   <= res_seg_q;
    end
  end

  // status
  assign stat_o.stamp_le = (rd_stamp <= offset_q);
  assign stat_o.at_first = (addr_q == '0);
  assign stat_o.at_last  = ((NW'(addr_q) + NW'(1)) == n_c);

  assign out_brightness_o    = out_level_q;
  assign out_segment_index_o = out_seg_q;

endmodule

// ===== hdl/kbi_controller.sv =====
// ----------------------------------------------------------------------------
// kbi_controller: sequencer for the keyframe brightness interpolator
// Runs the table scan, the multiply and the division steps, and owns the
// input stall and the output valid.
// ----------------------------------------------------------------------------
module kbi_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_operation_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  kbi_pkg::kbi_stat_t  stat_i,
  output kbi_pkg::kbi_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MUL,
    ST_DIV,
    ST_RES,
    ST_HOLD
  } state_e;

  state_e                       state_q, state_d;
  logic [kbi_pkg::DivCntW-1:0]  div_cnt_q, div_cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         in_acc;
  logic                         out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kbi_pkg::kbi_op_e'(in_operation_i) == kbi_pkg::OP_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_READ;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (stat_i.stamp_le) begin
          if (stat_i.at_last) begin
            cmd_o.take_last = 1'b1;
            state_d         = ST_HOLD;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_READ;
          end
        end else if (stat_i.at_first) begin
          cmd_o.take_first = 1'b1;
          state_d          = ST_HOLD;
        end else begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mult = 1'b1;
        div_cnt_d  = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + kbi_pkg::DivCntW'(1);
        if (div_cnt_q == kbi_pkg::DivCntW'(kbi_pkg::DivSteps - 1)) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        cmd_o.take_interp = 1'b1;
        state_d           = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
